@@ rtl/core/m3i_pkg.sv @@
package m3i_pkg;

	localparam int DIM     = 3;
	localparam int NELEM   = DIM * DIM;
	localparam int EW      = 32;
	localparam int ADJ_W   = 65;
	localparam int DET_W   = 97;
	localparam int ADET_W  = 96;
	localparam int NUM_W   = 98;
	localparam int CMP_W   = 130;
	localparam int QW      = 32;
	localparam int THR_W   = 31;

	localparam logic [QW-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] NEG_MAX = 32'h8000_0000;

	typedef logic signed [EW-1:0]    elem_t;
	typedef logic signed [ADJ_W-1:0] adj_t;

	typedef struct packed {
		logic              singular;
		logic              neg;
		logic [ADET_W-1:0] adet;
	} det_info_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [QW-1:0] q;
	} div_res_t;

endpackage

@@ rtl/core/matrix3x3_inverse_top.sv @@
// Throughput: one matrix per cycle; the nine divider lanes are fully pipelined, one quotient
// bit per stage, and the whole pipeline advances whenever the output register is free.
// Reset (arst_n low, asynchronous) empties the pipeline and sets zero_threshold to 1;
// datapath registers are not reset.
module matrix3x3_inverse_top import m3i_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Matrix in: m_r0c0, m_r0c1, m_r0c2, m_r1c0, ... m_r2c2, 32 bits each, lowest first.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [287:0]     s_tdata,
	// Inverse out: r_r0c0, r_r0c1, ... r_r2c2, 32 bits each, lowest first.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [287:0]     m_tdata,
	// Bit 0 singular, bit 1 saturated.
	output logic [1:0]       m_tuser,
	// zero_threshold write channel.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	localparam int ADJ_DLY = 6;
	localparam int LAST    = 44;
	localparam int SING_DLY = 35;

	logic             adv;
	logic [LAST:0]    v_q;
	logic [THR_W-1:0] thr_q;

	elem_t     mat_s0 [NELEM];
	elem_t     row0_s1 [DIM];
	elem_t     row0_s2 [DIM];
	adj_t      adj [NELEM];
	adj_t      adj_d [ADJ_DLY][NELEM];
	adj_t      det_adj [DIM];
	det_info_t dinfo;
	div_res_t  dres [NELEM];
	logic      sing_d [SING_DLY];

	logic [287:0] data_q;
	logic [1:0]   user_q;
	logic [QW-1:0] val [NELEM];
	logic          sat [NELEM];
	logic          any_sat;

	// The pipeline moves as one; it only stops when a finished result is not taken.
	assign adv       = !v_q[LAST] || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			thr_q <= THR_W'(1);
		end else begin
			if (adv) begin
				v_q <= {v_q[LAST-1:0], s_tvalid};
			end
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
		end
	end

	// Input register and a short copy of row 0 for the determinant.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NELEM; k++) begin
				mat_s0[k] <= s_tdata[k*EW +: EW];
			end
			for (int k = 0; k < DIM; k++) begin
				row0_s1[k] <= mat_s0[k];
				row0_s2[k] <= row0_s1[k];
			end
		end
	end

	// Cofactor lanes. Lane for row r, column c writes the transposed slot adj[c][r].
	for (genvar r = 0; r < DIM; r++) begin : g_row
		for (genvar c = 0; c < DIM; c++) begin : g_col
			localparam int R1 = (r + 1) % DIM;
			localparam int R2 = (r + 2) % DIM;
			localparam int C1 = (c + 1) % DIM;
			localparam int C2 = (c + 2) % DIM;
			m3i_cofactor u_cof (
				.clk (clk),
				.en  (adv),
				.a   (mat_s0[R1*DIM + C1]),
				.b   (mat_s0[R1*DIM + C2]),
				.c   (mat_s0[R2*DIM + C1]),
				.d   (mat_s0[R2*DIM + C2]),
				.adj (adj[c*DIM + r])
			);
		end
	end

	// The determinant is row 0 against column 0 of the adjugate.
	for (genvar c = 0; c < DIM; c++) begin : g_dadj
		assign det_adj[c] = adj[c*DIM];
	end

	m3i_det u_det (
		.clk  (clk),
		.en   (adv),
		.thr  (thr_q),
		.e    (row0_s2),
		.adj  (det_adj),
		.info (dinfo)
	);

	// Hold the adjugate until the determinant is ready, and the singular flag
	// until the quotients come out.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NELEM; k++) begin
				adj_d[0][k] <= adj[k];
				for (int j = 1; j < ADJ_DLY; j++) begin
					adj_d[j][k] <= adj_d[j-1][k];
				end
			end
			sing_d[0] <= dinfo.singular;
			for (int j = 1; j < SING_DLY; j++) begin
				sing_d[j] <= sing_d[j-1];
			end
		end
	end

	for (genvar k = 0; k < NELEM; k++) begin : g_div
		m3i_div u_div (
			.clk     (clk),
			.en      (adv),
			.adj     (adj_d[ADJ_DLY-1][k]),
			.adet    (dinfo.adet),
			.det_neg (dinfo.neg),
			.res     (dres[k])
		);
	end

	// Merge: sign and clip each quotient, collect the saturation flags.
	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < NELEM; k++) begin
			if (!dres[k].neg) begin
				sat[k] = dres[k].ovf || dres[k].q[QW-1];
				val[k] = sat[k] ? POS_MAX : dres[k].q;
			end else begin
				sat[k] = dres[k].ovf || (dres[k].q > NEG_MAX);
				val[k] = sat[k] ? NEG_MAX : QW'(-dres[k].q);
			end
			any_sat = any_sat | sat[k];
		end
	end

	// Output register; a singular matrix gives all zeros and no saturation.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NELEM; k++) begin
				data_q[k*EW +: EW] <= sing_d[SING_DLY-1] ? '0 : val[k];
			end
			user_q <= {any_sat && !sing_d[SING_DLY-1], sing_d[SING_DLY-1]};
		end
	end

	assign m_tvalid = v_q[LAST];
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

@@ rtl/core/m3i_cofactor.sv @@
module m3i_cofactor import m3i_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  elem_t a,
	input  elem_t b,
	input  elem_t c,
	input  elem_t d,
	output adj_t  adj
);

	logic signed [2*EW-1:0] p1_s1, p2_s1;
	adj_t                   adj_s2;

	// Two products, then their exact difference a*d - b*c.
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= a * d;
			p2_s1  <= b * c;
			adj_s2 <= ADJ_W'(p1_s1) - ADJ_W'(p2_s1);
		end
	end

	assign adj = adj_s2;

endmodule

@@ rtl/core/m3i_det.sv @@
module m3i_det import m3i_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [THR_W-1:0] thr,
	input  elem_t            e   [DIM],
	input  adj_t             adj [DIM],
	output det_info_t        info
);

	logic [EW-1:0]        em_s1  [DIM];
	logic [2*EW-1:0]      am_s1  [DIM];
	logic                 sg_s1  [DIM];
	logic [2*EW-1:0]      plo_s2 [DIM];
	logic [2*EW-1:0]      phi_s2 [DIM];
	logic                 sg_s2  [DIM];
	logic [ADET_W-1:0]    mag_s3 [DIM];
	logic                 sg_s3  [DIM];
	logic signed [DET_W-1:0] det_s4;
	logic [ADET_W-1:0]    adet_s5;
	logic                 neg_s5;
	det_info_t            info_s6;
	logic signed [DET_W-1:0] term [DIM];

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			term[k] = sg_s3[k] ? -$signed({1'b0, mag_s3[k]}) : $signed({1'b0, mag_s3[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIM; k++) begin
				em_s1[k]  <= e[k][EW-1] ? EW'(-e[k]) : EW'(e[k]);
				am_s1[k]  <= adj[k][ADJ_W-1] ? (2*EW)'(-adj[k]) : (2*EW)'(adj[k]);
				sg_s1[k]  <= e[k][EW-1] ^ adj[k][ADJ_W-1];
				plo_s2[k] <= am_s1[k][EW-1:0] * em_s1[k];
				phi_s2[k] <= am_s1[k][2*EW-1:EW] * em_s1[k];
				sg_s2[k]  <= sg_s1[k];
				mag_s3[k] <= {phi_s2[k], {EW{1'b0}}} + ADET_W'(plo_s2[k]);
				sg_s3[k]  <= sg_s2[k];
			end
			det_s4  <= term[0] + term[1] + term[2];
			neg_s5  <= det_s4[DET_W-1];
			adet_s5 <= det_s4[DET_W-1] ? ADET_W'(-det_s4) : ADET_W'(det_s4);
			info_s6.neg      <= neg_s5;
			info_s6.adet     <= adet_s5;
			info_s6.singular <= (adet_s5 == '0) ||
				(adet_s5 < ADET_W'({thr, {EW{1'b0}}}));
		end
	end

	assign info = info_s6;

endmodule

@@ rtl/core/m3i_div.sv @@
module m3i_div import m3i_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  adj_t              adj,
	input  logic [ADET_W-1:0] adet,
	input  logic              det_neg,
	output div_res_t          res
);

	logic [2*EW-1:0]   mag_sa;
	logic [ADET_W-1:0] adet_sa, adet_sb;
	logic              neg_sa, neg_sb;
	logic [NUM_W-1:0]  num_sb;

	// Index 0 is the overflow check stage, then one quotient bit per stage.
	logic [NUM_W-1:0]  rem_s  [QW+1];
	logic [QW-1:0]     q_s    [QW+1];
	logic [ADET_W-1:0] adet_s [QW+1];
	logic              neg_s  [QW+1];
	logic              ovf_s  [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sa  <= adj[ADJ_W-1] ? (2*EW)'(-adj) : (2*EW)'(adj);
			adet_sa <= adet;
			neg_sa  <= adj[ADJ_W-1] ^ det_neg;
			// Rounded quotient is (2*adj*2^32 + det) / (2*det).
			num_sb  <= NUM_W'({mag_sa, 33'b0}) + NUM_W'(adet_sa);
			adet_sb <= adet_sa;
			neg_sb  <= neg_sa;
			rem_s[0]  <= num_sb;
			q_s[0]    <= '0;
			adet_s[0] <= adet_sb;
			neg_s[0]  <= neg_sb;
			ovf_s[0]  <= CMP_W'(num_sb) >= CMP_W'({adet_sb, 33'b0});
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int B = QW - 1 - i;
		logic [CMP_W-1:0] dsh;
		logic             ge;
		assign dsh = CMP_W'(adet_s[i]) << (B + 1);
		assign ge  = CMP_W'(rem_s[i]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? rem_s[i] - dsh[NUM_W-1:0] : rem_s[i];
				q_s[i+1]    <= q_s[i] | (QW'(ge) << B);
				adet_s[i+1] <= adet_s[i];
				neg_s[i+1]  <= neg_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	assign res.neg = neg_s[QW];
	assign res.ovf = ovf_s[QW];
	assign res.q   = q_s[QW];

endmodule

@@ rtl/core/m3i_checker.sv @@
module m3i_checker import m3i_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [287:0]     m_tdata,
	input logic [1:0]       m_tuser
);

	logic any_clip;

	always_comb begin
		any_clip = 1'b0;
		for (int k = 0; k < NELEM; k++) begin
			any_clip = any_clip || (m_tdata[k*EW +: EW] == POS_MAX) ||
				(m_tdata[k*EW +: EW] == NEG_MAX);
		end
	end

	// A waiting result must stay put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// A free output slot always lets a new matrix in.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Singular results are all zero and never flagged as clipped.
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("singular result not cleared");

	// A clipped result shows at least one element at a range limit.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> any_clip)
		else $error("saturation flag without clipped element");

endmodule

bind matrix3x3_inverse_top m3i_checker u_m3i_checker (.*);

@@ bench/matrix3x3_inverse_top_test.sv @@
module matrix3x3_inverse_top_test;
	import m3i_pkg::*;

	// The expected inverse of one matrix, in the packed layout of the output stream.
	typedef struct {
		logic [NELEM*EW-1:0] elems;
		logic                singular;
		logic                saturated;
	} inverse_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [NELEM*EW-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [NELEM*EW-1:0]  m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [THR_W-1:0]     cfg_data;

	matrix3x3_inverse_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Matrices waiting to be sent, and inverses waiting to come back.
	logic [NELEM*EW-1:0] matrix_q[$];
	inverse_t            inverse_q[$];

	// The threshold as the predictor sees it, updated on each accepted write transaction.
	logic [THR_W-1:0] model_thresh;

	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_left;
	int mismatches;
	int n_sent;
	int n_checked;
	int n_singular;
	int n_saturated;
	longint cycles;

	// Exact inverse by the adjugate. Cofactors and the determinant are kept at full
	// width in 128 bits; each element is the rounded quotient adj * 2^32 / det on
	// magnitudes, with ties rounding away from zero, then signed and clipped.
	function automatic inverse_t invert_matrix(logic [NELEM*EW-1:0] mat,
			logic [THR_W-1:0] thresh);
		logic signed [EW-1:0]  m[DIM][DIM];
		logic signed [127:0]   adj[DIM][DIM];
		logic signed [127:0]   det;
		logic [127:0]          adet;
		logic [127:0]          limit;
		logic [127:0]          mag;
		logic [191:0]          quot;
		logic                  neg;
		logic [EW-1:0]         val;
		inverse_t              res;
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				m[r][c] = mat[(r*DIM+c)*EW +: EW];
			end
		end
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				adj[c][r] = m[(r+1)%DIM][(c+1)%DIM] * m[(r+2)%DIM][(c+2)%DIM]
					- m[(r+1)%DIM][(c+2)%DIM] * m[(r+2)%DIM][(c+1)%DIM];
			end
		end
		det = 0;
		for (int c = 0; c < DIM; c++) begin
			det = det + m[0][c] * adj[c][0];
		end
		adet = (det < 0) ? -det : det;
		limit = {65'd0, thresh, 32'd0};
		res.elems = '0;
		res.singular = 1'b0;
		res.saturated = 1'b0;
		if (adet == 0 || adet < limit) begin
			res.singular = 1'b1;
			return res;
		end
		for (int i = 0; i < NELEM; i++) begin
			mag = (adj[i/DIM][i%DIM] < 0) ? -adj[i/DIM][i%DIM] : adj[i/DIM][i%DIM];
			neg = (adj[i/DIM][i%DIM] < 0) != (det < 0);
			quot = (({64'd0, mag} << 33) + {64'd0, adet}) / ({64'd0, adet} << 1);
			if (!neg) begin
				if (quot > 192'(POS_MAX)) begin
					val = POS_MAX;
					res.saturated = 1'b1;
				end else begin
					val = quot[EW-1:0];
				end
			end else begin
				if (quot > 192'(NEG_MAX)) begin
					val = NEG_MAX;
					res.saturated = 1'b1;
				end else begin
					val = -quot[EW-1:0];
				end
			end
			res.elems[i*EW +: EW] = val;
		end
		return res;
	endfunction

	// One random matrix. Half are well-conditioned around the identity so that real
	// inverses come out; some are nearly singular, some raw random words, and some are
	// built from the extreme element values.
	function automatic logic [NELEM*EW-1:0] random_matrix();
		logic [NELEM*EW-1:0] mat;
		logic [EW-1:0]       extremes[5];
		int                  kind;
		kind = $urandom_range(0, 99);
		extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
		for (int i = 0; i < NELEM; i++) begin
			if (kind < 50) begin
				mat[i*EW +: EW] = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000
					+ ((i % 4 == 0) ? 32'h3_0000 : 32'h0);
			end else if (kind < 70) begin
				mat[i*EW +: EW] = (i < 6) ? $urandom_range(0, 32'h7_FFFF) - 32'h4_0000
					: mat[(i-6)*EW +: EW] + $urandom_range(0, 15) - 8;
			end else if (kind < 85) begin
				mat[i*EW +: EW] = $urandom;
			end else begin
				mat[i*EW +: EW] = ($urandom_range(0, 2) == 0) ? $urandom
					: extremes[$urandom_range(0, 4)];
			end
		end
		return mat;
	endfunction

	function automatic logic [NELEM*EW-1:0] diag_matrix(logic [EW-1:0] a, logic [EW-1:0] b,
			logic [EW-1:0] c);
		logic [NELEM*EW-1:0] mat;
		mat = '0;
		mat[0*EW +: EW] = a;
		mat[4*EW +: EW] = b;
		mat[8*EW +: EW] = c;
		return mat;
	endfunction

	function automatic logic [NELEM*EW-1:0] fill_matrix(logic [EW-1:0] v);
		return {NELEM{v}};
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: a matrix stays on the bus until its transaction completes, and the
	// expected inverse is computed at that edge with the threshold then in force.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				inverse_q.push_back(invert_matrix(s_tdata, model_thresh));
				void'(matrix_q.pop_front());
				n_sent++;
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (matrix_q.size() > 0
					&& $urandom_range(0, 99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= matrix_q[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold, counted down one cycle at a time.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compares every completed output transaction with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					$error("unexpected output transaction: no inverse pending");
					mismatches++;
				end else begin
					inverse_t exp_inv;
					exp_inv = inverse_q.pop_front();
					n_checked++;
					n_singular += exp_inv.singular;
					n_saturated += exp_inv.saturated;
					for (int i = 0; i < NELEM; i++) begin
						if (m_tdata[i*EW +: EW] !== exp_inv.elems[i*EW +: EW]) begin
							$error("r_r%0dc%0d: expected %h, got %h", i / DIM, i % DIM,
								exp_inv.elems[i*EW +: EW], m_tdata[i*EW +: EW]);
							mismatches++;
						end
					end
					if (m_tuser[0] !== exp_inv.singular) begin
						$error("singular: expected %b, got %b", exp_inv.singular, m_tuser[0]);
						mismatches++;
					end
					if (m_tuser[1] !== exp_inv.saturated) begin
						$error("saturated: expected %b, got %b", exp_inv.saturated,
							m_tuser[1]);
						mismatches++;
					end
				end
			end
			// A pending hold keeps the output back for a long stretch, so the pipeline
			// fills and the input side has to stall.
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles, %0d inverses outstanding", cycles,
				inverse_q.size());
			$display("matrix3x3_inverse_top_test: done, errors");
			$finish;
		end
	end

	// Threshold writes happen only with the block drained; the extra wait covers the
	// pipeline latency.
	task automatic write_threshold(logic [THR_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		model_thresh = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (matrix_q.size() > 0 || s_tvalid || inverse_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic run_phase(logic [THR_W-1:0] thresh, int idle_pct, int stall_pct,
			int count, int hold);
		write_threshold(thresh);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		hold_left = hold;
		for (int i = 0; i < count; i++) begin
			matrix_q.push_back(random_matrix());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_thresh = 1;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		n_sent = 0;
		n_checked = 0;
		n_singular = 0;
		n_saturated = 0;
		cycles = 0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// Directed part with the reset threshold: identity, scaled diagonals whose
		// inverse clips both ways, the zero matrix, equal rows, extreme fills and a
		// general matrix with mixed signs.
		matrix_q.push_back(diag_matrix(32'h1_0000, 32'h1_0000, 32'h1_0000));
		matrix_q.push_back(diag_matrix(32'h2_0000, 32'hFFFE_0000, 32'h0_8000));
		matrix_q.push_back(diag_matrix(32'h3_0000, 32'h3_0000, 32'h3_0000));
		matrix_q.push_back(diag_matrix(32'h1, 32'h1_0000, 32'h1_0000));
		matrix_q.push_back(diag_matrix(32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000));
		matrix_q.push_back(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		matrix_q.push_back(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		matrix_q.push_back(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h1));
		matrix_q.push_back(diag_matrix(32'h100, 32'h100, 32'h100));
		matrix_q.push_back(diag_matrix(32'h10, 32'h10, 32'h10));
		matrix_q.push_back(fill_matrix(32'h0));
		matrix_q.push_back(fill_matrix(32'h7FFF_FFFF));
		matrix_q.push_back(fill_matrix(32'h8000_0000));
		matrix_q.push_back(fill_matrix(32'hFFFF_FFFF));
		matrix_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		matrix_q.push_back({32'h0004_0000, 32'hFFFE_8000, 32'h0001_0000,
			32'h0000_4000, 32'h0003_0000, 32'hFFFF_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0005_0000});
		matrix_q.push_back({32'h0002_0000, 32'h0001_0000, 32'h0003_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0003_0000,
			32'h0001_0000, 32'h0004_0000, 32'h0002_0000});
		matrix_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'h8000_0000});
		drain();

		// With the threshold at zero only an exactly zero determinant is singular.
		write_threshold(0);
		matrix_q.push_back(fill_matrix(32'h0));
		matrix_q.push_back(diag_matrix(32'h1, 32'h1, 32'h1));
		matrix_q.push_back(diag_matrix(32'h1, 32'h0, 32'h1));
		drain();

		run_phase(1, 0, 0, 120, 0);
		run_phase(0, 70, 0, 100, 0);
		run_phase({THR_W{1'b1}}, 0, 70, 100, 0);
		run_phase(31'h1_0000, 18, 18, 150, 0);
		run_phase(31'h100, 0, 0, 100, 500);
		run_phase(THR_W'($urandom_range(0, 32'h7FFF_FFFF)), 30, 30, 80, 0);

		if (inverse_q.size() > 0) begin
			$error("%0d expected inverses never arrived", inverse_q.size());
			mismatches++;
		end
		$display("Checked %0d of %0d matrices: %0d singular, %0d with clipped elements,",
			n_checked, n_sent, n_singular, n_saturated);
		$display("over six threshold settings and several idle and stall mixes.");
		if (mismatches == 0) begin
			$display("matrix3x3_inverse_top_test: done, clean");
		end else begin
			$display("matrix3x3_inverse_top_test: done, errors");
		end
		$finish;
	end

endmodule

@@ matrix3x3_inverse_top.f @@
rtl/core/m3i_pkg.sv
rtl/core/m3i_cofactor.sv
rtl/core/m3i_det.sv
rtl/core/m3i_div.sv
rtl/core/matrix3x3_inverse_top.sv
rtl/core/m3i_checker.sv
bench/matrix3x3_inverse_top_test.sv
